### src/bdgd_pkg.sv
`timescale 1ns / 1ps

package bdgd_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_DEBOUNCE_SAMPLES    = 3'd0,
    CFG_CLICK_MAX_TICKS     = 3'd1,
    CFG_DOUBLE_WINDOW_TICKS = 3'd2,
    CFG_LONG_PRESS_TICKS    = 3'd3,
    CFG_GUARD_TICKS         = 3'd4,
    CFG_ACTIVE_LOW          = 3'd5,
    CFG_INJECT_PRESS_TICKS  = 3'd6,
    CFG_INJECT_SETTLE_TICKS = 3'd7
  } cfg_idx_e;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 8;

  // reset values of the configuration registers
  localparam logic [7:0]  DebounceSamplesRst   = 8'd3;
  localparam logic [15:0] ClickMaxTicksRst     = 16'd70;
  localparam logic [15:0] DoubleWindowTicksRst = 16'd20;
  localparam logic [15:0] LongPressTicksRst    = 16'd120;
  localparam logic [15:0] GuardTicksRst        = 16'd200;
  localparam logic        ActiveLowRst         = 1'b1;
  localparam logic [7:0]  InjectPressTicksRst  = 8'd8;
  localparam logic [7:0]  InjectSettleTicksRst = 8'd8;

  // result item, packed highest field first (stable_level is bit 0)
  typedef struct packed {
    logic [2:0] pad;
    logic       long_press;
    logic       double_click;
    logic       single_click;
    logic       is_pressed;
    logic       stable_level;
  } result_t;

endpackage

### src/button_debounce_gesture_detector.sv
`timescale 1ns / 1ps
// the result of an accepted request is registered and shown on the master side in the next cycle
// throughput: one request per cycle while the master side takes results; the result register frees as it is taken
// the whole tick update (debounce, gesture and window counters) is one
// combinational pass into the state and result registers
// reset (rst_ni low, asynchronous) clears the tick state and result valid and loads default config

module button_debounce_gesture_detector (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [0] raw_level, [1] inject_click, [2] recording_on, [7:3] zero
  input  logic [bdgd_pkg::InDataW-1:0]      s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [0] stable_level, [1] is_pressed, [2] single_click, [3] double_click,
  // [4] long_press, [7:5] zero
  output logic [bdgd_pkg::OutDataW-1:0]     m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [bdgd_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [bdgd_pkg::CfgDataW-1:0]     cfg_data_i
);

  // configuration
  logic [7:0]  deb_samples_q, inj_press_q, inj_settle_q;
  logic [15:0] click_max_q, window_q, long_q, guard_q;
  logic        active_low_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_samples_q <= bdgd_pkg::DebounceSamplesRst;
      click_max_q   <= bdgd_pkg::ClickMaxTicksRst;
      window_q      <= bdgd_pkg::DoubleWindowTicksRst;
      long_q        <= bdgd_pkg::LongPressTicksRst;
      guard_q       <= bdgd_pkg::GuardTicksRst;
      active_low_q  <= bdgd_pkg::ActiveLowRst;
      inj_press_q   <= bdgd_pkg::InjectPressTicksRst;
      inj_settle_q  <= bdgd_pkg::InjectSettleTicksRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (bdgd_pkg::cfg_idx_e'(cfg_index_i))
        bdgd_pkg::CFG_DEBOUNCE_SAMPLES:    deb_samples_q <= cfg_data_i[7:0];
        bdgd_pkg::CFG_CLICK_MAX_TICKS:     click_max_q   <= cfg_data_i;
        bdgd_pkg::CFG_DOUBLE_WINDOW_TICKS: window_q      <= cfg_data_i;
        bdgd_pkg::CFG_LONG_PRESS_TICKS:    long_q        <= cfg_data_i;
        bdgd_pkg::CFG_GUARD_TICKS:         guard_q       <= cfg_data_i;
        bdgd_pkg::CFG_ACTIVE_LOW:          active_low_q  <= cfg_data_i[0];
        bdgd_pkg::CFG_INJECT_PRESS_TICKS:  inj_press_q   <= cfg_data_i[7:0];
        bdgd_pkg::CFG_INJECT_SETTLE_TICKS: inj_settle_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // tick state
  logic        init_q, init_d;
  logic        last_q, last_d;
  logic        deb_q, deb_d;
  logic [7:0]  run_q, run_d;
  logic        pflag_q, pflag_d;
  logic [15:0] hold_q, hold_d;
  logic        longr_q, longr_d;
  logic        pend_q, pend_d;
  logic [15:0] pticks_q, pticks_d;
  logic        inj_act_q, inj_act_d;
  logic [8:0]  inj_el_q, inj_el_d;
  logic        rec_prev_q, rec_prev_d;
  logic        seen_q, seen_d;
  logic [15:0] since_q, since_d;

  logic        out_valid_q;
  logic [bdgd_pkg::OutDataW-1:0] out_data_q;

  logic        accept;
  logic        raw, inject, rec_on;
  logic        level, pressed, allowed;
  logic        single_p, double_p, long_p;
  logic [8:0]  inj_end;
  bdgd_pkg::result_t res;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign raw           = s_axis_tdata[0];
  assign inject        = s_axis_tdata[1];
  assign rec_on        = s_axis_tdata[2];
  assign inj_end       = {1'b0, inj_press_q} + {1'b0, inj_settle_q};

  always_comb begin
    init_d     = init_q;
    last_d     = last_q;
    deb_d      = deb_q;
    run_d      = run_q;
    pflag_d    = pflag_q;
    hold_d     = hold_q;
    longr_d    = longr_q;
    pend_d     = pend_q;
    pticks_d   = pticks_q;
    inj_act_d  = inj_act_q;
    inj_el_d   = inj_el_q;
    rec_prev_d = rec_on;
    seen_d     = seen_q;
    since_d    = since_q;
    single_p   = 1'b0;
    double_p   = 1'b0;
    long_p     = 1'b0;
    pressed    = 1'b0;
    level      = raw;

    // recording change tracking
    if (rec_on != rec_prev_q) begin
      since_d = '0;
      seen_d  = 1'b1;
    end else if (since_q != '1) begin
      since_d = since_q + 16'd1;
    end
    allowed = !rec_on && (!seen_d || since_d >= guard_q);

    // an injection before the first sample sets a high idle level first
    if (inject) begin
      if (!init_q) begin
        init_d   = 1'b1;
        last_d   = 1'b1;
        deb_d    = 1'b1;
        run_d    = 8'd1;
        pflag_d  = 1'b0;
        hold_d   = '0;
        pend_d   = 1'b0;
        pticks_d = '0;
        longr_d  = 1'b0;
      end
      inj_act_d = 1'b1;
      inj_el_d  = '0;
    end

    if (inj_act_d) begin
      if (inj_el_d < {1'b0, inj_press_q}) begin
        level = 1'b0;
      end else if (inj_el_d < inj_end) begin
        level = 1'b1;
      end else begin
        inj_act_d = 1'b0;
      end
      if (inj_el_d != '1) inj_el_d = inj_el_d + 9'd1;
    end

    if (!init_d) begin
      init_d   = 1'b1;
      last_d   = level;
      deb_d    = level;
      run_d    = 8'd1;
      pflag_d  = 1'b0;
      hold_d   = '0;
      pend_d   = 1'b0;
      pticks_d = '0;
      longr_d  = 1'b0;
    end else if (level != last_d) begin
      last_d = level;
      run_d  = 8'd1;
    end else begin
      if (run_d != '1) run_d = run_d + 8'd1;
      if (run_d >= deb_samples_q) begin
        deb_d   = level;
        pressed = level ^ active_low_q;
        if (pressed && !pflag_d) begin
          hold_d  = '0;
          longr_d = 1'b0;
        end else if (!pressed && pflag_d) begin
          if (!longr_d && hold_d <= click_max_q) begin
            if (pend_d && allowed) begin
              pend_d   = 1'b0;
              pticks_d = '0;
              double_p = 1'b1;
            end else begin
              // blocked double click still counts as a single
              if (pend_d) single_p = 1'b1;
              pend_d   = 1'b1;
              pticks_d = '0;
            end
          end
          hold_d  = '0;
          longr_d = 1'b0;
        end else if (pressed && !longr_d) begin
          if (hold_d != '1) hold_d = hold_d + 16'd1;
          if (hold_d >= long_q) begin
            longr_d  = 1'b1;
            pend_d   = 1'b0;
            pticks_d = '0;
            long_p   = 1'b1;
          end
        end
        pflag_d = pressed;
        // double-click window
        if (!pflag_d && pend_d) begin
          if (pticks_d != '1) pticks_d = pticks_d + 16'd1;
          if (pticks_d >= window_q) begin
            pend_d   = 1'b0;
            pticks_d = '0;
            single_p = 1'b1;
          end
        end
      end
    end

    res.pad          = '0;
    res.long_press   = long_p;
    res.double_click = double_p;
    res.single_click = single_p;
    res.is_pressed   = pflag_d;
    res.stable_level = deb_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 1'b0;
      last_q     <= 1'b0;
      deb_q      <= 1'b0;
      run_q      <= '0;
      pflag_q    <= 1'b0;
      hold_q     <= '0;
      longr_q    <= 1'b0;
      pend_q     <= 1'b0;
      pticks_q   <= '0;
      inj_act_q  <= 1'b0;
      inj_el_q   <= '0;
      rec_prev_q <= 1'b0;
      seen_q     <= 1'b0;
      since_q    <= '0;
    end else if (accept) begin
      init_q     <= init_d;
      last_q     <= last_d;
      deb_q      <= deb_d;
      run_q      <= run_d;
      pflag_q    <= pflag_d;
      hold_q     <= hold_d;
      longr_q    <= longr_d;
      pend_q     <= pend_d;
      pticks_q   <= pticks_d;
      inj_act_q  <= inj_act_d;
      inj_el_q   <= inj_el_d;
      rec_prev_q <= rec_prev_d;
      seen_q     <= seen_d;
      since_q    <= since_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### src/bdgd_checker.sv
`timescale 1ns / 1ps

module bdgd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid_i,
  input logic                          m_axis_tready_i,
  input logic [bdgd_pkg::OutDataW-1:0] m_axis_tdata_i
);

  logic stable_w, pressed_w, single_w, double_w, long_w;

  assign stable_w  = m_axis_tdata_i[0];
  assign pressed_w = m_axis_tdata_i[1];
  assign single_w  = m_axis_tdata_i[2];
  assign double_w  = m_axis_tdata_i[3];
  assign long_w    = m_axis_tdata_i[4];

  // one gesture per tick at most
  a_one_gesture: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_i |-> $onehot0({single_w, double_w, long_w}))
    else $error("more than one gesture pulse in a result");

  // long press fires while still held
  a_long_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && long_w) |-> pressed_w)
    else $error("long press without pressed state");

  // clicks are reported only when released
  a_click_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && (single_w || double_w)) |-> !pressed_w)
    else $error("click reported while pressed");

  // stalled result holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_i && !m_axis_tready_i) |=>
      (m_axis_tvalid_i && $stable(m_axis_tdata_i) && $stable(stable_w)))
    else $error("result changed under stall");

endmodule

bind button_debounce_gesture_detector bdgd_checker u_bdgd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_i (m_axis_tvalid),
  .m_axis_tready_i (m_axis_tready),
  .m_axis_tdata_i  (m_axis_tdata)
);
